[hw/rtl/q2e_pkg.sv]
// shared types, constants and functions of the quaternion to euler block
`default_nettype none
package q2e_pkg;

  localparam int FRAC_BITS    = 15;
  localparam int CORDIC_STEPS = 16;
  localparam int COMP_W       = 16;
  localparam int ANGLE_W      = 16;
  localparam int PROD_W       = 2 * COMP_W;
  localparam int SUM_W        = PROD_W + 3;
  localparam int TERM_SHIFT   = 2 * (COMP_W - 1) - FRAC_BITS;
  localparam int TERM_W       = FRAC_BITS + 5;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [TERM_W-1:0] t23;
    logic signed [TERM_W-1:0] t22;
    logic signed [TERM_W-1:0] t31;
    logic signed [TERM_W-1:0] t11;
    logic signed [TERM_W-1:0] t21;
  } term_t;

  function automatic logic [31:0] atan_lut(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/q2e_front.sv]
// front end: component products and rotation-matrix terms
`default_nettype none
module q2e_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [4*q2e_pkg::COMP_W-1:0] in_data_i,
  output logic                           term_valid_o,
  input  wire logic                      term_ready_i,
  output q2e_pkg::term_t                 term_o
);
  import q2e_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] ww, aa, bb, cc, bc, wa, ac, wb, wc, ab;
  } prod_t;

  logic                     en;
  logic                     v1_q, v1_d, v2_q, v2_d;
  prod_t                    p_q, p_d;
  term_t                    t_q, t_d;
  logic signed [COMP_W-1:0] w, a, b, c;
  logic signed [SUM_W-1:0]  s23, s22, s31, s11, s21;

  assign en = !v2_q || term_ready_i;
  assign in_ready_o = en;
  assign term_valid_o = v2_q;
  assign term_o = t_q;

  always_comb begin
    w = in_data_i[COMP_W-1:0];
    a = in_data_i[2*COMP_W-1:COMP_W];
    b = in_data_i[3*COMP_W-1:2*COMP_W];
    c = in_data_i[4*COMP_W-1:3*COMP_W];
    p_d.ww = w * w;
    p_d.aa = a * a;
    p_d.bb = b * b;
    p_d.cc = c * c;
    p_d.bc = b * c;
    p_d.wa = w * a;
    p_d.ac = a * c;
    p_d.wb = w * b;
    p_d.wc = w * c;
    p_d.ab = a * b;
    s23 = (SUM_W'(p_q.bc) - SUM_W'(p_q.wa)) <<< 1;
    s22 = SUM_W'(p_q.ww) - SUM_W'(p_q.aa) + SUM_W'(p_q.bb) - SUM_W'(p_q.cc);
    s31 = (SUM_W'(p_q.ac) - SUM_W'(p_q.wb)) <<< 1;
    s11 = SUM_W'(p_q.ww) + SUM_W'(p_q.aa) - SUM_W'(p_q.bb) - SUM_W'(p_q.cc);
    s21 = (SUM_W'(p_q.wc) + SUM_W'(p_q.ab)) <<< 1;
    t_d.t23 = TERM_W'(s23 >>> TERM_SHIFT);
    t_d.t22 = TERM_W'(s22 >>> TERM_SHIFT);
    t_d.t31 = TERM_W'(s31 >>> TERM_SHIFT);
    t_d.t11 = TERM_W'(s11 >>> TERM_SHIFT);
    t_d.t21 = TERM_W'(s21 >>> TERM_SHIFT);
    v1_d = in_valid_i;
    v2_d = v1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
      t_q <= t_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/q2e_fifo.sv]
// short queue of terms between front and back
`default_nettype none
module q2e_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire q2e_pkg::term_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output q2e_pkg::term_t      rd_data_o
);
  import q2e_pkg::*;

  term_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (PTR_W+1)'(FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d = wr ? wp_q + 1'b1 : wp_q;
    rp_d = rd ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/q2e_back.sv]
// back end: square-root ladder and three vectoring cordic pipelines
`default_nettype none
module q2e_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire q2e_pkg::term_t                  term_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [3*q2e_pkg::ANGLE_W-1:0]        out_data_o
);
  import q2e_pkg::*;

  localparam int SQ_STEPS = FRAC_BITS + 1;
  localparam int NW       = 2 * FRAC_BITS + 2;
  localparam int CW       = TERM_W + 3;
  localparam int ZW       = 34;
  localparam int STAGES   = SQ_STEPS + CORDIC_STEPS + 3;
  localparam logic signed [TERM_W-1:0] ONE_T = TERM_W'(1) <<< FRAC_BITS;

  typedef struct packed {
    term_t           t;
    logic [NW-1:0]   n;
    logic [NW-1:0]   r;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cv_t;

  typedef struct packed {
    cv_t roll;
    cv_t yaw;
    cv_t pitch;
  } cd_t;

  function automatic cv_t pre_rot(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    cv_t o;
    o.zero = (x == '0) && (y == '0);
    o.x = x;
    o.y = y;
    o.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        o.x = y;
        o.y = -x;
        o.z = ZW'(1) <<< 30;
      end else begin
        o.x = -y;
        o.y = x;
        o.z = -(ZW'(1) <<< 30);
      end
    end
    return o;
  endfunction

  function automatic cv_t step(input cv_t c, input int i);
    cv_t o;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    dx = c.y >>> i;
    dy = c.x >>> i;
    at = $signed({2'b00, atan_lut(i)});
    o.zero = c.zero;
    if (c.y >= 0) begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + at;
    end else begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - at;
    end
    return o;
  endfunction

  function automatic logic [ANGLE_W-1:0] angle16(input cv_t c);
    logic signed [ZW-1:0] s;
    s = c.z + ZW'(32768);
    return c.zero ? '0 : s[ANGLE_W+15:16];
  endfunction

  function automatic logic signed [CW-1:0] ext(input logic signed [TERM_W-1:0] t);
    return {{(CW-TERM_W){t[TERM_W-1]}}, t};
  endfunction

  logic                      en;
  logic [STAGES-1:0]         vld_q;
  sq_t                       sq_q [SQ_STEPS+1];
  sq_t                       sq_nx [SQ_STEPS];
  sq_t                       sq0_d;
  cd_t                       cd_q [CORDIC_STEPS+1];
  cd_t                       cd_nx [CORDIC_STEPS];
  cd_t                       cd0_d;
  logic [3*ANGLE_W-1:0]      out_q, out_d;
  logic signed [TERM_W-1:0]  sat;
  logic [FRAC_BITS:0]        mag;
  logic [2*FRAC_BITS+1:0]    mag2;
  logic signed [CW-1:0]      sx;
  logic [ANGLE_W-1:0]        roll_a, yaw_a, pitch_a;

  assign en = !vld_q[STAGES-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[STAGES-1];
  assign out_data_o = out_q;

  always_comb begin
    sat = term_i.t21;
    if (term_i.t21 > ONE_T) begin
      sat = ONE_T;
    end else if (term_i.t21 < -ONE_T) begin
      sat = -ONE_T;
    end
    mag = sat[TERM_W-1] ? (FRAC_BITS+1)'(0) - sat[FRAC_BITS:0] : sat[FRAC_BITS:0];
    mag2 = mag * mag;
    sq0_d.t = term_i;
    sq0_d.t.t21 = sat;
    sq0_d.n = (NW'(1) << (2 * FRAC_BITS)) - NW'(mag2);
    sq0_d.r = '0;
  end

  always_comb begin
    logic [NW-1:0] bitv, rb;
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv = NW'(1) << (2 * (SQ_STEPS - 1 - k));
      rb = sq_q[k].r + bitv;
      sq_nx[k] = sq_q[k];
      if (sq_q[k].n >= rb) begin
        sq_nx[k].n = sq_q[k].n - rb;
        sq_nx[k].r = (sq_q[k].r >> 1) + bitv;
      end else begin
        sq_nx[k].r = sq_q[k].r >> 1;
      end
    end
  end

  always_comb begin
    sx = {{(CW-FRAC_BITS-1){1'b0}}, sq_q[SQ_STEPS].r[FRAC_BITS:0]};
    cd0_d.roll = pre_rot(ext(sq_q[SQ_STEPS].t.t23), ext(sq_q[SQ_STEPS].t.t22));
    cd0_d.yaw = pre_rot(ext(sq_q[SQ_STEPS].t.t31), ext(sq_q[SQ_STEPS].t.t11));
    cd0_d.pitch = pre_rot(ext(sq_q[SQ_STEPS].t.t21), sx);
  end

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      cd_nx[i].roll = step(cd_q[i].roll, i);
      cd_nx[i].yaw = step(cd_q[i].yaw, i);
      cd_nx[i].pitch = step(cd_q[i].pitch, i);
    end
  end

  always_comb begin
    roll_a = angle16(cd_q[CORDIC_STEPS].roll);
    yaw_a = angle16(cd_q[CORDIC_STEPS].yaw);
    pitch_a = angle16(cd_q[CORDIC_STEPS].pitch);
    out_d = {pitch_a, ANGLE_W'(0) - yaw_a, ANGLE_W'(0) - roll_a};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= sq0_d;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_q[k+1] <= sq_nx[k];
      end
      cd_q[0] <= cd0_d;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cd_q[i+1] <= cd_nx[i];
      end
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/quaternion_to_euler_top.sv]
// top level of the quaternion to euler angle converter
`default_nettype none
// Converts one Q1.15 attitude quaternion per transfer into roll, yaw and
// pitch binary angles (32768 = pi). A new quaternion is taken every clock
// cycle unless the front is stalled; each result passes through 38 register
// stages: product and term stages, one slot in the four-entry queue, the
// pitch saturation stage, sixteen square-root steps, a pre-rotation stage,
// sixteen cordic stages and the output register.
// Back-pressure on the output stalls the back pipeline; the queue lets the
// front keep accepting until it fills.
module quaternion_to_euler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // q_w, q_x, q_y, q_z
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o    // roll_angle, yaw_angle, pitch_angle
);
  import q2e_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  term_t f_term, b_term;

  q2e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .term_valid_o (f_valid),
    .term_ready_i (f_ready),
    .term_o       (f_term)
  );

  q2e_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_term),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_term)
  );

  q2e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .term_i      (b_term),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

[test/q2e_checker.sv]
// checker for the quaternion to euler block: predicts angles and compares transfers
`default_nettype none
module q2e_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [63:0] s_data_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [47:0] m_data_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] angles_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan2_fx(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd1 << 30;
      end else begin
        t = x; x = -y; y = t; z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < q2e_pkg::CORDIC_STEPS && i < 32; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(q2e_pkg::atan_lut(i));
      end else begin
        x -= dx; y += dy; z -= longint'(q2e_pkg::atan_lut(i));
      end
    end
    return z;
  endfunction

  function automatic longint to_angle(longint z);
    return floor_shr(z + 32768, 16);
  endfunction

  function automatic longint to_frac(longint v);
    if (30 - q2e_pkg::FRAC_BITS >= 0) return floor_shr(v, 30 - q2e_pkg::FRAC_BITS);
    return v <<< (q2e_pkg::FRAC_BITS - 30);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [47:0] predict_angles(logic [63:0] q);
    longint w, a, b, c, t23, t22, t31, t11, t21, one, mag, s;
    logic [15:0] roll, yaw, pitch;
    w = longint'($signed(q[15:0]));
    a = longint'($signed(q[31:16]));
    b = longint'($signed(q[47:32]));
    c = longint'($signed(q[63:48]));
    t23 = to_frac(2 * (b * c - w * a));
    t22 = to_frac(w * w - a * a + b * b - c * c);
    t31 = to_frac(2 * (a * c - w * b));
    t11 = to_frac(w * w + a * a - b * b - c * c);
    t21 = to_frac(2 * (w * c + a * b));
    one = 64'sd1 << q2e_pkg::FRAC_BITS;
    if (t21 > one) t21 = one;
    if (t21 < -one) t21 = -one;
    mag = t21 < 0 ? -t21 : t21;
    s = int_sqrt((64'sd1 << (2 * q2e_pkg::FRAC_BITS)) - mag * mag);
    roll  = 16'(-to_angle(atan2_fx(t23, t22)));
    yaw   = 16'(-to_angle(atan2_fx(t31, t11)));
    pitch = 16'(to_angle(atan2_fx(t21, s)));
    return {pitch, yaw, roll};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [47:0] want;
    int          bad;
    if (!rst_ni) begin
      errors_o <= 0;
      angles_q.delete();
    end else begin
      bad = 0;
      if (s_valid_i && s_ready_i) angles_q.push_back(predict_angles(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (angles_q.size() == 0) begin
          $display("%0t unexpected transfer, actual %h", $time, m_data_i);
          bad = 1;
        end else begin
          want = angles_q.pop_front();
          for (int f = 0; f < 3; f++)
            if (want[16*f +: 16] != m_data_i[16*f +: 16]) begin
              $display("%0t field %0d expected %h actual %h", $time, f,
                       want[16*f +: 16], m_data_i[16*f +: 16]);
              bad = bad + 1;
            end
        end
      end
      errors_o <= errors_o + bad;
    end
  end

  assign pending_o = angles_q.size();
endmodule
`default_nettype wire

[test/tb_quaternion_to_euler_top.sv]
// stimulus and verdict for the quaternion to euler block
`default_nettype none
module tb_quaternion_to_euler_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  int          errors, pending, idle_cycles;
  logic        fired;

  initial forever #1 clk_i = ~clk_i;

  quaternion_to_euler_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data)
  );

  q2e_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] comp_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // unit quaternion from a random direction, scaled near Q1.15 one
  function automatic logic [63:0] unit_quat();
    real v[4], n;
    logic [15:0] c[4];
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      v[i] = ($urandom_range(0, 65535) - 32767.5) / 32768.0;
      n += v[i] * v[i];
    end
    n = $sqrt(n) + 1e-9;
    for (int i = 0; i < 4; i++) c[i] = 16'($rtoi(v[i] / n * 32760.0));
    return {c[3], c[2], c[1], c[0]};
  endfunction

  task automatic send(logic [63:0] q);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= q;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // receive side stalls
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      m_ready <= 1'b0;
      repeat (g) @(posedge clk_i);
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    fired = (s_valid && s_ready) || (m_valid && m_ready);
    idle_cycles = fired ? 0 : idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] ext[4];
    idle_cycles = 0;
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: identity, half turns, zero, extremes
    send({16'h0000, 16'h0000, 16'h0000, 16'h7FFF});
    send({16'h0000, 16'h0000, 16'h0000, 16'h8000});
    send(64'h0);
    send({16'h0000, 16'h0000, 16'h7FFF, 16'h0000});
    send({16'h0000, 16'h7FFF, 16'h0000, 16'h0000});
    send({16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    send({16'h5A82, 16'h0000, 16'h0000, 16'h5A82});
    send({16'h5A82, 16'h0000, 16'h0000, 16'hA57E});
    send({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    for (int i = 0; i < 4; i++) send({ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[i]});
    send(64'h5555_AAAA_5555_AAAA);
    send(64'hAAAA_5555_AAAA_5555);
    for (int i = 0; i < 1500; i++) begin
      if (i == 700) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 3) == 0)
        send({comp_val(), comp_val(), comp_val(), comp_val()});
      else
        send(unit_quat());
    end
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
